>>> rtl/core/lkl_pkg.sv
`timescale 1ns / 1ps

package lkl_pkg;

   // Input opcodes.
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   // Width of the raw capacity register.
   localparam int CAP_W = 5;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] key_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] key_out;
      logic               hit;
      logic               evicted;
      logic               is_last;
      logic               list_empty;
   } rsp_type;

   // What every cell of the chain does in a cycle.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'b00,
      CELL_ACCESS = 2'b01,
      CELL_ROTATE = 2'b10
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] key;
      logic               hit;
   } cell_ctrl_type;

endpackage

>>> rtl/core/lru_key_list_top.sv
`timescale 1ns / 1ps

// Move-to-front recency list of up to MAX_ENTRIES keys, most recent first.
// The list lives in a chain of cells; each cell holds one key and takes its
// neighbor's key when the list shifts.
// Input channel: an item transfers at a rising edge with start high and busy
// low. An access (opcode 0) compares every held key at once, updates the
// list in that same edge and strobes its single result on rsp_valid in the
// next cycle, so accesses can follow each other in every cycle.
// A dump (opcode 1) raises busy for as long as the dump runs; the
// chain rotates by one cell each cycle and the head key is sent, one result
// per cycle, head to tail, the last one marked with is_last. After the full
// rotation the list is back in order and busy drops. An empty list answers a
// dump with one result marked list_empty, in the next cycle, without busy.
// Results are strobed for one cycle and the receiver cannot hold them off.
// The capacity register sits at byte address 0 of the APB port; writing a
// value below the occupancy drops the least recent keys at once. A value of
// zero acts as one, a value above MAX_ENTRIES as MAX_ENTRIES.
// Reset empties the list and sets the capacity to 16; it needs no clearing
// pass, since only positions below the occupancy are ever read.
module lru_key_list_top #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lkl_pkg::req_type req_data,
   output logic             rsp_valid,
   output lkl_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import lkl_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
      logic [CMP_W-1:0] cx;
      logic [CMP_W-1:0] mx;
      begin
         cx = CMP_W'(c);
         mx = CMP_W'(MAX_ENTRIES);
         if (c == '0) begin
            eff_cap = CNT_W'(1);
         end else if (cx > mx) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
         end else begin
            eff_cap = CNT_W'(cx);
         end
      end
   endfunction

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic             dump_ff, dump_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic                          accept;
   logic                          cfg_write;
   logic [CNT_W-1:0]              ecap;
   logic [CNT_W-1:0]              new_cap;
   logic [CNT_W-1:0]              last_idx;
   logic [CNT_W-1:0]              shift_lim;
   logic                          full;
   logic                          hit;
   logic                          dump_last;
   cell_ctrl_type                 ctrl;
   logic [MAX_ENTRIES-1:0][31:0]  keys;

   assign accept    = start && !dump_ff;
   assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign ecap      = eff_cap(cap_ff);
   assign new_cap   = eff_cap(pwdata[CAP_W-1:0]);
   assign last_idx  = occ_ff - CNT_W'(1);
   assign full      = occ_ff >= ecap;
   // A miss inserts at the head: a full list drops its tail, otherwise the
   // list grows by one cell.
   assign shift_lim = full ? (ecap - CNT_W'(1)) : occ_ff;
   assign dump_last = CNT_W'(cnt_ff) == last_idx;

   always_comb begin
      ctrl.key = req_data.key_in;
      ctrl.hit = hit;
      if (dump_ff) begin
         ctrl.op = CELL_ROTATE;
      end else if (accept && (req_data.opcode == OP_ACCESS)) begin
         ctrl.op = CELL_ACCESS;
      end else begin
         ctrl.op = CELL_HOLD;
      end
   end

   lkl_chain #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_chain (
      .clock    (clock),
      .ctrl     (ctrl),
      .occ      (occ_ff),
      .shift_lim(shift_lim),
      .last_idx (last_idx),
      .found    (hit),
      .keys     (keys)
   );

   always_comb begin
      cap_in       = cap_ff;
      occ_in       = occ_ff;
      dump_in      = dump_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      if (cfg_write) begin
         // Lowering the capacity drops the least recent keys silently.
         cap_in = pwdata[CAP_W-1:0];
         if (occ_ff > new_cap) begin
            occ_in = new_cap;
         end
      end

      if (dump_ff) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.key_out    = keys[0];
         rsp_data_in.hit        = 1'b0;
         rsp_data_in.evicted    = 1'b0;
         rsp_data_in.is_last    = dump_last;
         rsp_data_in.list_empty = 1'b0;
         cnt_in                 = cnt_ff + IDX_W'(1);
         if (dump_last) begin
            dump_in = 1'b0;
         end
      end else if (accept) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.key_out    = '0;
         rsp_data_in.hit        = 1'b0;
         rsp_data_in.evicted    = 1'b0;
         rsp_data_in.is_last    = 1'b1;
         rsp_data_in.list_empty = 1'b0;
         if (req_data.opcode == OP_DUMP) begin
            if (occ_ff == '0) begin
               rsp_data_in.list_empty = 1'b1;
            end else begin
               // The results of a dump come from the rotating chain.
               rsp_valid_in = 1'b0;
               dump_in      = 1'b1;
               cnt_in       = '0;
            end
         end else if (hit) begin
            rsp_data_in.hit = 1'b1;
         end else if (full) begin
            // A full list holds exactly ecap keys; the tail goes out.
            rsp_data_in.evicted = 1'b1;
            rsp_data_in.key_out = keys[last_idx[IDX_W-1:0]];
         end else begin
            occ_in = occ_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         dump_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         dump_ff      <= dump_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = dump_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == 1'b0) ? 32'(cap_ff) : 32'd0;

   // The dump ends only with the tail key going out, marked last.
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_data.is_last))
      else $error("dump ended without a last-marked result");

   // The list never holds more keys than the effective capacity.
   a_occ_cap: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= ecap)
      else $error("occupancy above capacity");

   // Every access transfer answers with exactly one result in the next cycle.
   a_access_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.opcode == OP_ACCESS))
         |=> (rsp_valid && rsp_data.is_last && !rsp_data.list_empty))
      else $error("access result missing");

   // A hit never evicts.
   a_hit_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.evicted))
      else $error("hit and eviction in one result");

endmodule

>>> rtl/core/lkl_cell.sv
`timescale 1ns / 1ps

module lkl_cell #(
   parameter int MAX_ENTRIES = 16,
   parameter int IDX         = 0
) (
   input  logic                           clock,
   input  lkl_pkg::cell_ctrl_type         ctrl,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] occ,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] shift_lim,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] last_idx,
   input  logic signed [31:0]             prev_key,
   input  logic signed [31:0]             next_key,
   input  logic signed [31:0]             head_key,
   input  logic                           found_in,
   output logic                           found_out,
   output logic signed [31:0]             key_out
);
   import lkl_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic signed [31:0] key_ff;
   logic signed [31:0] key_in;
   logic               held;

   // A cell holds a key when its position lies below the occupancy.
   assign held      = MY_IDX < occ;
   assign found_out = found_in | (held && (key_ff == ctrl.key));
   assign key_out   = key_ff;

   always_comb begin
      key_in = key_ff;
      case (ctrl.op)
         CELL_ACCESS: begin
            // On a hit, every cell up to the matching one takes its upstream
            // neighbor; on a miss, every cell up to the shift limit does.
            if (ctrl.hit ? !found_in : (MY_IDX <= shift_lim)) begin
               key_in = prev_key;
            end
         end
         CELL_ROTATE: begin
            if (held) begin
               key_in = (MY_IDX == last_idx) ? head_key : next_key;
            end
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

>>> rtl/core/lkl_chain.sv
`timescale 1ns / 1ps

module lkl_chain #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                             clock,
   input  lkl_pkg::cell_ctrl_type           ctrl,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] occ,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] shift_lim,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] last_idx,
   output logic                             found,
   output logic [MAX_ENTRIES-1:0][31:0]     keys
);
   import lkl_pkg::*;

   logic [MAX_ENTRIES:0] found_chain;

   assign found_chain[0] = 1'b0;
   assign found          = found_chain[MAX_ENTRIES];

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic signed [31:0] prev_key;
      logic signed [31:0] next_key;
      logic signed [31:0] cell_key;

      if (g == 0) begin : g_head
         assign prev_key = ctrl.key;
      end else begin : g_body
         assign prev_key = keys[g-1];
      end

      if (g == MAX_ENTRIES - 1) begin : g_tail
         assign next_key = keys[0];
      end else begin : g_inner
         assign next_key = keys[g+1];
      end

      lkl_cell #(
         .MAX_ENTRIES(MAX_ENTRIES),
         .IDX        (g)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .occ      (occ),
         .shift_lim(shift_lim),
         .last_idx (last_idx),
         .prev_key (prev_key),
         .next_key (next_key),
         .head_key (keys[0]),
         .found_in (found_chain[g]),
         .found_out(found_chain[g+1]),
         .key_out  (cell_key)
      );

      assign keys[g] = cell_key;
   end

endmodule
